@@ hdl/plc_pkg.sv @@
// Shared types, constants and register indexes of the path leg cost evaluator.
package plc_pkg;

  // Field widths.
  localparam int COORD_WIDTH     = 32;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int GAIN_WIDTH      = 16;
  localparam int AREA_WIDTH      = 16;
  localparam int DIST_WIDTH      = 24;
  localparam int COST_WIDTH      = 32;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 24;

  // Register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOPE_K    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLEAR_BIAS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CELL_SIZE  = 2'd2;

  // Depth of the queue between the front and the back.
  localparam int FIFO_DEPTH = 4;

  // Hold level of the intermediate products and the largest cost.
  localparam logic [32:0]           HOLD_CAP = 33'h1_0000_0000;
  localparam logic [COST_WIDTH-1:0] COST_MAX = '1;

  // One request as it arrives.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] from_z;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
    logic signed [COORD_WIDTH-1:0] to_z;
    logic [AREA_WIDTH-1:0]         area_multiplier;
    logic [DIST_WIDTH-1:0]         clearance;
    logic                          to_is_crossing;
  } leg_item_t;

  // One result.
  typedef struct packed {
    logic [COST_WIDTH-1:0] leg_cost;
    logic                  cost_saturated;
  } leg_cost_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic [COORD_WIDTH-1:0] dx;
    logic [COORD_WIDTH-1:0] dy;
    logic [COORD_WIDTH-1:0] dz;
    logic [AREA_WIDTH-1:0]  area;
    logic [DIST_WIDTH-1:0]  clearance;
    logic                   clr_on;
  } leg_delta_t;

  // Queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ hdl/plc_front.sv @@
// Front part: takes a request, forms the axis distances and classifies the clearance case.
module plc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  plc_pkg::leg_item_t                item,
  input  logic [plc_pkg::GAIN_WIDTH-1:0]    bias_k,
  input  logic [plc_pkg::DIST_WIDTH-1:0]    cell_size,
  input  plc_pkg::fifo_stat_t               stat,
  output logic                              push,
  output plc_pkg::leg_delta_t               delta
);

  localparam int CW = plc_pkg::COORD_WIDTH;

  logic               held_valid;
  plc_pkg::leg_item_t held;

  // Absolute difference of two signed coordinates.
  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] d;
    logic [CW:0] n;
    d = {a[CW-1], a} - {b[CW-1], b};
    n = -d;
    return d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  // The holding register frees as soon as its request moves into the queue.
  assign item_ready = !held_valid || !stat.full;
  assign push       = held_valid && !stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      held <= item;
    end
  end

  // Distances and the clearance classification.
  always_comb begin
    delta.dx        = abs_diff(held.to_x, held.from_x);
    delta.dy        = abs_diff(held.to_y, held.from_y);
    delta.dz        = abs_diff(held.to_z, held.from_z);
    delta.area      = held.area_multiplier;
    delta.clearance = held.clearance;
    delta.clr_on    = (bias_k != '0) && (cell_size != '0) && held.to_is_crossing;
  end

endmodule

@@ hdl/plc_fifo.sv @@
// Short queue that parts the front from the arithmetic back.
module plc_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  plc_pkg::leg_delta_t  wdata,
  input  logic                 pop,
  output plc_pkg::leg_delta_t  rdata,
  output plc_pkg::fifo_stat_t  stat
);

  localparam int DEPTH = plc_pkg::FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  plc_pkg::leg_delta_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10: begin
          count <= count + CNT_W'(1);
        end
        2'b01: begin
          count <= count - CNT_W'(1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue fill level beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue fill level did not rise on a lone write");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr == rd_ptr + PTR_W'(count))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

@@ hdl/plc_back.sv @@
// Back part: pipelined squares, square roots, divisions and cost products.
module plc_back #(
  parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [plc_pkg::GAIN_WIDTH-1:0]  slope_k,
  input  logic [plc_pkg::GAIN_WIDTH-1:0]  bias_k,
  input  logic [plc_pkg::DIST_WIDTH-1:0]  cell_size,
  input  plc_pkg::leg_delta_t             head,
  input  logic                            head_valid,
  output logic                            pop,
  output logic                            cost_valid,
  input  logic                            cost_ready,
  output plc_pkg::leg_cost_t              cost
);

  localparam int CW  = plc_pkg::COORD_WIDTH;
  localparam int LO  = CW / 2;
  localparam int HI  = CW - LO;
  localparam int SQW = 2 * CW + 2;
  localparam int RW  = CW + 1;
  localparam int KW  = plc_pkg::GAIN_WIDTH;
  localparam int AW  = plc_pkg::AREA_WIDTH;
  localparam int DW  = plc_pkg::DIST_WIDTH;
  localparam int KDW = KW + CW;
  localparam int CNW = KW + DW;
  localparam int CDW = DW + 1;
  localparam int CFW = KW + 1;
  localparam int SQ  = 32 + FRAC_BITS;
  localparam int SW  = SQ + 1;
  localparam int SL  = SW / 2;
  localparam int SH  = SW - SL;
  localparam int NX  = SQ + RW;
  localparam int PW  = 33;
  localparam int P1W = RW + AW;
  localparam int P2W = PW + SW;
  localparam int P3W = PW + CFW;
  localparam int OW  = plc_pkg::COST_WIDTH;

  localparam logic [SW-1:0]  ONE_S     = SW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]  SLOPE_CAP = SW'(1) << SQ;
  localparam logic [CFW-1:0] ONE_C     = CFW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [SQW-1:0]  len2;
    logic [SQW-1:0]  run2;
    logic [RW-1:0]   lroot;
    logic [RW-1:0]   rroot;
    logic [RW+1:0]   lrem;
    logic [RW+1:0]   rrem;
    logic [KDW-1:0]  kdz;
    logic [CNW-1:0]  cnum;
    logic [CDW-1:0]  cden;
    logic [CDW-1:0]  crem;
    logic [KW-1:0]   cq;
    logic [AW-1:0]   area;
    logic            clr_on;
  } sq_stage_t;

  typedef struct packed {
    logic [RW-1:0]   drem;
    logic [SQ-1:0]   dq;
    logic [SQ-1:0]   dlow;
    logic [RW-1:0]   rdiv;
    logic            sat;
    logic            zero_run;
    logic [PW-1:0]   p1;
    logic [CFW-1:0]  cfac;
  } div_stage_t;

  // The whole back advances together unless the result register is stalled.
  logic en;
  assign en  = !cost_valid || cost_ready;
  assign pop = en && head_valid;

  // One square-root iteration: two radicand bits in, one root bit out.
  function automatic logic [2*RW+1:0] sqrt_step(input logic [RW+1:0] rem,
                                                input logic [RW-1:0] root,
                                                input logic [1:0]    pair);
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    diff  = t - trial;
    if (t >= trial) begin
      return {diff[RW+1:0], root[RW-2:0], 1'b1};
    end
    return {t[RW+1:0], root[RW-2:0], 1'b0};
  endfunction

  // One step of the clearance division: returns the new remainder and quotient bit.
  function automatic logic [CDW:0] cdiv_step(input logic [CDW-1:0] rem,
                                             input logic [CDW-1:0] den,
                                             input logic           nbit);
    logic [CDW:0] t;
    logic [CDW:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[CDW-1:0], 1'b1};
    end
    return {t[CDW-1:0], 1'b0};
  endfunction

  // Stage 1: partial products of the squares, the slope numerator and the clearance terms.
  logic [CW-1:0]      d [3];
  logic               s1_valid;
  logic [2*LO-1:0]    s1_ll [3];
  logic [LO+HI-1:0]   s1_lh [3];
  logic [2*HI-1:0]    s1_hh [3];
  logic [KDW-1:0]     s1_kdz;
  logic [CNW-1:0]     s1_cnum;
  logic [CDW-1:0]     s1_cden;
  logic [AW-1:0]      s1_area;
  logic               s1_clr_on;

  assign d[0] = head.dx;
  assign d[1] = head.dy;
  assign d[2] = head.dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ll[i] <= (2*LO)'(d[i][LO-1:0]) * (2*LO)'(d[i][LO-1:0]);
        s1_lh[i] <= (LO+HI)'(d[i][LO-1:0]) * (LO+HI)'(d[i][CW-1:LO]);
        s1_hh[i] <= (2*HI)'(d[i][CW-1:LO]) * (2*HI)'(d[i][CW-1:LO]);
      end
      s1_kdz    <= KDW'(slope_k) * KDW'(head.dz);
      s1_cnum   <= CNW'(bias_k) * CNW'(cell_size);
      s1_cden   <= CDW'(head.clearance) + CDW'(cell_size);
      s1_area   <= head.area;
      s1_clr_on <= head.clr_on;
    end
  end

  // Stage 2: the three squares put together from their partial products.
  logic            s2_valid;
  logic [2*CW-1:0] s2_sq [3];
  logic [KDW-1:0]  s2_kdz;
  logic [CNW-1:0]  s2_cnum;
  logic [CDW-1:0]  s2_cden;
  logic [AW-1:0]   s2_area;
  logic            s2_clr_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= ((2*CW)'(s1_hh[i]) << (2*LO)) + ((2*CW)'(s1_lh[i]) << (LO+1))
                    + (2*CW)'(s1_ll[i]);
      end
      s2_kdz    <= s1_kdz;
      s2_cnum   <= s1_cnum;
      s2_cden   <= s1_cden;
      s2_area   <= s1_area;
      s2_clr_on <= s1_clr_on;
    end
  end

  // Stage 3: squared run and squared length; the root and division start from here.
  logic      s3_valid;
  sq_stage_t s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.run2   <= SQW'(s2_sq[0]) + SQW'(s2_sq[1]);
      s3.len2   <= SQW'(s2_sq[0]) + SQW'(s2_sq[1]) + SQW'(s2_sq[2]);
      s3.lroot  <= '0;
      s3.rroot  <= '0;
      s3.lrem   <= '0;
      s3.rrem   <= '0;
      s3.kdz    <= s2_kdz;
      s3.cnum   <= s2_cnum;
      s3.cden   <= s2_cden;
      s3.crem   <= CDW'(s2_cnum[CNW-1:KW]);
      s3.cq     <= '0;
      s3.area   <= s2_area;
      s3.clr_on <= s2_clr_on;
    end
  end

  // Square-root stages, one root bit each; the clearance quotient shares the first ones.
  sq_stage_t sqs      [RW];
  logic      sq_valid [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    sq_stage_t src;
    sq_stage_t nxt;
    logic      src_valid;

    if (j == 0) begin : g_first
      assign src       = s3;
      assign src_valid = s3_valid;
    end else begin : g_next
      assign src       = sqs[j-1];
      assign src_valid = sq_valid[j-1];
    end

    if (j < KW) begin : g_cdiv
      always_comb begin
        logic [CDW:0] cstep;
        nxt = src;
        {nxt.lrem, nxt.lroot} = sqrt_step(src.lrem, src.lroot, src.len2[SQW-1-2*j -: 2]);
        {nxt.rrem, nxt.rroot} = sqrt_step(src.rrem, src.rroot, src.run2[SQW-1-2*j -: 2]);
        cstep    = cdiv_step(src.crem, src.cden, src.cnum[KW-1-j]);
        nxt.crem = cstep[CDW:1];
        nxt.cq   = {src.cq[KW-2:0], cstep[0]};
      end
    end else begin : g_root_only
      always_comb begin
        nxt = src;
        {nxt.lrem, nxt.lroot} = sqrt_step(src.lrem, src.lroot, src.len2[SQW-1-2*j -: 2]);
        {nxt.rrem, nxt.rroot} = sqrt_step(src.rrem, src.rroot, src.run2[SQW-1-2*j -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[j] <= 1'b0;
      end else if (en) begin
        sq_valid[j] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sqs[j] <= nxt;
      end
    end
  end

  // Division set-up: steep-leg test, first remainder, length times area, clearance factor.
  logic             di_valid;
  div_stage_t       di;
  logic [P1W-1:0]   di_prod1;
  logic [NX-1:0]    num_ext;

  assign num_ext = NX'(sqs[RW-1].kdz);

  always_ff @(posedge clk) begin
    if (rst) begin
      di_valid <= 1'b0;
    end else if (en) begin
      di_valid <= sq_valid[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      di.drem     <= num_ext[NX-1:SQ];
      di.dq       <= '0;
      di.dlow     <= num_ext[SQ-1:0];
      di.rdiv     <= sqs[RW-1].rroot;
      di.sat      <= num_ext[NX-1:SQ] >= sqs[RW-1].rroot;
      di.zero_run <= sqs[RW-1].rroot == '0;
      di.p1       <= '0;
      di.cfac     <= sqs[RW-1].clr_on ? ONE_C + CFW'(sqs[RW-1].cq) : ONE_C;
      di_prod1    <= P1W'(sqs[RW-1].lroot) * P1W'(sqs[RW-1].area);
    end
  end

  // Slope division stages, one quotient bit each.
  div_stage_t dvs      [SQ];
  logic       dv_valid [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_div
    div_stage_t src;
    div_stage_t nxt;
    logic       src_valid;

    if (j == 0) begin : g_first
      assign src       = di;
      assign src_valid = di_valid;
    end else begin : g_next
      assign src       = dvs[j-1];
      assign src_valid = dv_valid[j-1];
    end

    always_comb begin
      logic [RW:0]    t;
      logic [RW:0]    diff;
      logic [P1W-1:0] p1s;
      nxt  = src;
      t    = {src.drem, src.dlow[SQ-1-j]};
      diff = t - {1'b0, src.rdiv};
      if (t >= {1'b0, src.rdiv}) begin
        nxt.drem = diff[RW-1:0];
        nxt.dq   = {src.dq[SQ-2:0], 1'b1};
      end else begin
        nxt.drem = t[RW-1:0];
        nxt.dq   = {src.dq[SQ-2:0], 1'b0};
      end
      // The first stage also holds the length-area product at its cap.
      p1s = di_prod1 >> FRAC_BITS;
      if (j == 0) begin
        nxt.p1 = (p1s > P1W'(plc_pkg::HOLD_CAP)) ? plc_pkg::HOLD_CAP : PW'(p1s);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (en) begin
        dv_valid[j] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dvs[j] <= nxt;
      end
    end
  end

  // Slope factor and its two partial products with the first cost term.
  logic            m_valid;
  logic [PW+SL-1:0] m_lo;
  logic [PW+SH-1:0] m_hi;
  logic [CFW-1:0]  m_cfac;
  logic [SW-1:0]   slope;

  always_comb begin
    if (dvs[SQ-1].zero_run) begin
      slope = ONE_S;
    end else begin
      slope = ONE_S + (dvs[SQ-1].sat ? SLOPE_CAP : SW'(dvs[SQ-1].dq));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= dv_valid[SQ-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_lo   <= (PW+SL)'(dvs[SQ-1].p1) * (PW+SL)'(slope[SL-1:0]);
      m_hi   <= (PW+SH)'(dvs[SQ-1].p1) * (PW+SH)'(slope[SW-1:SL]);
      m_cfac <= dvs[SQ-1].cfac;
    end
  end

  // Second cost term, held at its cap.
  logic            n_valid;
  logic [PW-1:0]   n_p2;
  logic [CFW-1:0]  n_cfac;
  logic [P2W-1:0]  prod2;
  logic [P2W-1:0]  p2s;

  assign prod2 = (P2W'(m_hi) << SL) + P2W'(m_lo);
  assign p2s   = prod2 >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else if (en) begin
      n_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_p2   <= (p2s > P2W'(plc_pkg::HOLD_CAP)) ? plc_pkg::HOLD_CAP : PW'(p2s);
      n_cfac <= m_cfac;
    end
  end

  // Clearance product.
  logic           q_valid;
  logic [P3W-1:0] q_prod3;
  logic [P3W-1:0] p3s;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_prod3 <= P3W'(n_p2) * P3W'(n_cfac);
    end
  end

  // Result register with the final clip.
  assign p3s = q_prod3 >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cost_valid <= 1'b0;
    end else if (en) begin
      cost_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (p3s > P3W'(plc_pkg::COST_MAX)) begin
        cost.leg_cost       <= plc_pkg::COST_MAX;
        cost.cost_saturated <= 1'b1;
      end else begin
        cost.leg_cost       <= OW'(p3s);
        cost.cost_saturated <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/path_leg_cost_evaluator.sv @@
// Top level of the path leg cost evaluator: registers, front, queue and back.
// The path from request to result runs through the one-bit-per-stage square-root
// and slope-division pipelines in the back.
// Throughput: one request per cycle; the back stalls as a whole only while a result waits,
// and the queue lets the front keep taking requests until it fills.
// Reset: synchronous, active high; zeroes valid flags, queue pointers and config registers.
module path_leg_cost_evaluator #(
  parameter int FRAC_BITS = plc_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  plc_pkg::leg_item_t                   item,
  output logic                                 cost_valid,
  input  logic                                 cost_ready,
  output plc_pkg::leg_cost_t                   cost,
  input  logic                                 cfg_we,
  input  logic [plc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [plc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

  logic [plc_pkg::GAIN_WIDTH-1:0] slope_k;
  logic [plc_pkg::GAIN_WIDTH-1:0] bias_k;
  logic [plc_pkg::DIST_WIDTH-1:0] cell_size;

  plc_pkg::fifo_stat_t stat;
  plc_pkg::leg_delta_t delta;
  plc_pkg::leg_delta_t head;
  logic                push;
  logic                pop;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_k   <= '0;
      bias_k    <= '0;
      cell_size <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        plc_pkg::CFG_SLOPE_K: begin
          slope_k <= cfg_data[plc_pkg::GAIN_WIDTH-1:0];
        end
        plc_pkg::CFG_CLEAR_BIAS: begin
          bias_k <= cfg_data[plc_pkg::GAIN_WIDTH-1:0];
        end
        plc_pkg::CFG_CELL_SIZE: begin
          cell_size <= cfg_data[plc_pkg::DIST_WIDTH-1:0];
        end
        default: begin
          slope_k <= slope_k;
        end
      endcase
    end
  end

  plc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .bias_k     (bias_k),
    .cell_size  (cell_size),
    .stat       (stat),
    .push       (push),
    .delta      (delta)
  );

  plc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (delta),
    .pop   (pop),
    .rdata (head),
    .stat  (stat)
  );

  plc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .slope_k    (slope_k),
    .bias_k     (bias_k),
    .cell_size  (cell_size),
    .head       (head),
    .head_valid (!stat.empty),
    .pop        (pop),
    .cost_valid (cost_valid),
    .cost_ready (cost_ready),
    .cost       (cost)
  );

endmodule

@@ tb/tb_path_leg_cost_evaluator.sv @@
// Self-checking testbench for the path leg cost evaluator.
`timescale 1ns / 1ps

module tb_path_leg_cost_evaluator;
  import plc_pkg::*;

  localparam int ONE_SHIFT     = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES  = 120;
  localparam int WATCHDOG_MAX  = 5000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  leg_item_t item = '0;
  logic      cost_valid;
  logic      cost_ready = 1'b0;
  leg_cost_t cost;
  logic      cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  // Shadow copies of the configuration registers.
  logic [GAIN_WIDTH-1:0] slope_gain = '0;
  logic [GAIN_WIDTH-1:0] bias_gain  = '0;
  logic [DIST_WIDTH-1:0] cell_len   = '0;

  leg_cost_t pending_costs[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_request = 0;
  int        stall_left = 0;
  int        quiet_cycles = 0;

  path_leg_cost_evaluator dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .cost_valid(cost_valid), .cost_ready(cost_ready), .cost(cost),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Integer square root, truncating.
  function automatic logic [63:0] int_sqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  // Distance between two signed coordinates along one axis.
  function automatic logic [63:0] axis_span(logic signed [COORD_WIDTH-1:0] a,
                                            logic signed [COORD_WIDTH-1:0] b);
    longint sa;
    longint sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? 64'(sa - sb) : 64'(sb - sa);
  endfunction

  // Cost of one leg under the current register settings.
  function automatic leg_cost_t leg_cost_of(leg_item_t it);
    logic [127:0] dx, dy, dz, run2, len2, quot, prod;
    logic [63:0]  len, run, slope, clr;
    leg_cost_t    res;
    dx = 128'(axis_span(it.to_x, it.from_x));
    dy = 128'(axis_span(it.to_y, it.from_y));
    dz = 128'(axis_span(it.to_z, it.from_z));
    run2 = dx * dx + dy * dy;
    len2 = run2 + dz * dz;
    len  = int_sqrt(len2);
    run  = int_sqrt(run2);
    slope = 64'd1 << ONE_SHIFT;
    if (run != 0) begin
      quot = ({112'd0, slope_gain} * dz) / {64'd0, run};
      if (quot > (128'd1 << (32 + ONE_SHIFT))) quot = 128'd1 << (32 + ONE_SHIFT);
      slope = slope + quot[63:0];
    end
    clr = 64'd1 << ONE_SHIFT;
    if (bias_gain != 0 && cell_len != 0 && it.to_is_crossing)
      clr = clr + (64'(bias_gain) * 64'(cell_len)) / (64'(it.clearance) + 64'(cell_len));
    prod = ({64'd0, len} * {112'd0, it.area_multiplier}) >> ONE_SHIFT;
    if (prod > 128'(HOLD_CAP)) prod = 128'(HOLD_CAP);
    prod = (prod * {64'd0, slope}) >> ONE_SHIFT;
    if (prod > 128'(HOLD_CAP)) prod = 128'(HOLD_CAP);
    prod = (prod * {64'd0, clr}) >> ONE_SHIFT;
    if (prod > 128'(HOLD_CAP)) prod = 128'(HOLD_CAP);
    if (prod > 128'(COST_MAX)) begin
      res.leg_cost = COST_MAX;
      res.cost_saturated = 1'b1;
    end else begin
      res.leg_cost = prod[COST_WIDTH-1:0];
      res.cost_saturated = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Record the expected cost of every accepted request.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) pending_costs.push_back(leg_cost_of(item));
  end

  // Receiver: random or forced stalls, and the check of each result.
  always @(posedge clk) begin
    leg_cost_t want;
    if (!rst && cost_valid && cost_ready) begin
      if (pending_costs.size() == 0) begin
        report_mismatch("unexpected result", cost.leg_cost, 0);
      end else begin
        want = pending_costs.pop_front();
        if (cost.leg_cost !== want.leg_cost)
          report_mismatch("leg_cost", cost.leg_cost, want.leg_cost);
        if (cost.cost_saturated !== want.cost_saturated)
          report_mismatch("cost_saturated", cost.cost_saturated, want.cost_saturated);
      end
    end
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      cost_ready <= 1'b0;
    end else begin
      cost_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (cost_valid && cost_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Watchdog expired");
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one request, after a random gap, and wait until it is taken.
  task automatic send_leg(leg_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // Let the pipeline empty before any register write.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gains(logic [GAIN_WIDTH-1:0] k, logic [GAIN_WIDTH-1:0] bias,
                             logic [DIST_WIDTH-1:0] grid_len);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SLOPE_K;
    cfg_data <= CFG_DATA_WIDTH'(k);
    @(posedge clk);
    cfg_index <= CFG_CLEAR_BIAS;
    cfg_data <= CFG_DATA_WIDTH'(bias);
    @(posedge clk);
    cfg_index <= CFG_CELL_SIZE;
    cfg_data <= grid_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    slope_gain = k;
    bias_gain = bias;
    cell_len = grid_len;
    @(posedge clk);
  endtask

  function automatic leg_item_t make_leg(int fx, int fy, int fz, int tx, int ty, int tz,
                                         int area, int clear, bit crossing);
    leg_item_t it;
    it.from_x = fx; it.from_y = fy; it.from_z = fz;
    it.to_x = tx;   it.to_y = ty;   it.to_z = tz;
    it.area_multiplier = area[AREA_WIDTH-1:0];
    it.clearance = clear[DIST_WIDTH-1:0];
    it.to_is_crossing = crossing;
    return it;
  endfunction

  // Offset along one axis, mostly short so that costs stay in range.
  function automatic int random_offset();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed($urandom_range(8191)) - 4096;
      4, 5, 6:    return $signed($urandom_range(2097151)) - 1048576;
      7:          return 0;
      default:    return $urandom;
    endcase
  endfunction

  function automatic leg_item_t random_leg();
    leg_item_t it;
    it.from_x = $urandom; it.from_y = $urandom; it.from_z = $urandom;
    it.to_x = it.from_x + random_offset();
    it.to_y = it.from_y + random_offset();
    it.to_z = it.from_z + random_offset();
    if ($urandom_range(7) == 0) it.to_x = $urandom;
    it.area_multiplier = ($urandom_range(9) == 0) ? AREA_WIDTH'($urandom_range(255))
                                                  : AREA_WIDTH'($urandom);
    it.clearance = DIST_WIDTH'($urandom);
    it.to_is_crossing = 1'($urandom);
    return it;
  endfunction

  // Edge cases: empty, vertical and extreme legs, both area extremes,
  // crossing on and off, clearance at both ends.
  task automatic test_directed_legs;
    send_leg(make_leg(0, 0, 0, 0, 0, 0, 256, 0, 1'b1));
    send_leg(make_leg(100, 200, -300, 100, 200, 5000, 256, 0, 1'b1));
    send_leg(make_leg(0, 0, 0, 3 << 8, 4 << 8, 0, 256, 256, 1'b1));
    send_leg(make_leg(0, 0, 0, 3 << 8, 4 << 8, 12 << 8, 512, 16777215, 1'b1));
    send_leg(make_leg(-2147483648, -2147483648, -2147483648,
                      2147483647, 2147483647, 2147483647, 65535, 16777215, 1'b1));
    send_leg(make_leg(2147483647, 0, 0, -2147483648, 0, 0, 256, 0, 1'b0));
    send_leg(make_leg(0, 0, 0, 1000, -1000, 200, 0, 100, 1'b1));
    send_leg(make_leg(0, 0, 0, 1000, -1000, 200, 65535, 100, 1'b0));
    send_leg(make_leg(0, 0, 0, 1, 0, 2147483647, 256, 0, 1'b1));
    send_leg(make_leg(5, 5, 5, 5, 5, -2147483648, 256, 0, 1'b1));
    send_leg(make_leg(-1, -1, -1, 1, 1, 1, 1, 16777215, 1'b1));
    send_leg(make_leg(0, 0, 0, 65536, 0, 0, 255, 0, 1'b1));
  endtask

  task automatic test_random_legs(int count);
    for (int n = 0; n < count; n++) send_leg(random_leg());
  endtask

  // Hold the receiver off for longer than the block can absorb, so that the
  // queue and the pipeline fill and the input stalls.
  task automatic test_backpressure;
    stall_request = 400;
    test_random_legs(120);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 49;
    test_directed_legs();
    write_gains(16'hFFFF, 16'hFFFF, 24'h000100);
    test_directed_legs();

    write_gains(16'h0100, 16'h0080, 24'h000400);
    test_random_legs(140);
    write_gains(16'h0000, 16'h0000, 24'h000000);
    test_random_legs(120);

    send_idle_pct = 49;
    recv_idle_pct = 27;
    write_gains(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    test_random_legs(120);
    write_gains(GAIN_WIDTH'($urandom), GAIN_WIDTH'($urandom), DIST_WIDTH'($urandom));
    test_backpressure();
    test_random_legs(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gains(16'h0040, 16'h0200, 24'h000001);
    test_random_legs(140);
    write_gains(GAIN_WIDTH'($urandom), GAIN_WIDTH'($urandom),
                DIST_WIDTH'($urandom_range(65535)));
    test_random_legs(140);

    drain();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/plc_pkg.sv
hdl/plc_front.sv
hdl/plc_fifo.sv
hdl/plc_back.sv
hdl/path_leg_cost_evaluator.sv
tb/tb_path_leg_cost_evaluator.sv
